@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge with reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ design/vdir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdir_pkg
// Widths, register indexes, controller states and command/status types.
// ----------------------------------------------------------------------------
package vdir_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int DELAY_W    = 24;
   localparam int RATE_W     = 16;
   localparam int LEN_CFG_W  = 17;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 17;
   localparam int PROD_W     = DELAY_W + RATE_W + 1;

   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES_PER_MS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_LENGTH  = 8'd1;

   localparam logic [RATE_W-1:0]    RATE_RESET = 16'd11290;
   localparam logic [LEN_CFG_W-1:0] LEN_RESET  = 17'd65536;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WRITE,
      S_CLAMP,
      S_ADDR,
      S_READ,
      S_BLEND
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic write_head;
      logic clamp;
      logic addr;
      logic read;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_full;
   } status_type;

endpackage

@@ design/vdir_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdir_req_if
// Input channel: sample to write and requested delay.
// ----------------------------------------------------------------------------
interface vdir_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [vdir_pkg::SAMPLE_W-1:0] write_sample;
   logic signed [vdir_pkg::DELAY_W-1:0]  delay_ms;

   modport source (output valid, output write_sample, output delay_ms, input ready);
   modport sink   (input valid, input write_sample, input delay_ms, output ready);
endinterface

@@ design/vdir_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdir_rsp_if
// Result channel: interpolated delayed sample.
// ----------------------------------------------------------------------------
interface vdir_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [vdir_pkg::SAMPLE_W-1:0] read_sample;

   modport source (output valid, output read_sample, input ready);
   modport sink   (input valid, input read_sample, output ready);
endinterface

@@ design/vdir_csr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdir_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface vdir_csr_if;
   logic                              valid;
   logic                              ready;
   logic [vdir_pkg::CSR_IDX_W-1:0]    index;
   logic [vdir_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/vdir_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdir_ctrl
// Sequencer: memory clear after reset, then write, clamp, address, read, blend.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vdir_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  vdir_pkg::status_type status,
   output vdir_pkg::cmd_type    cmd
);

   vdir_pkg::state_type state_ff;
   vdir_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vdir_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         vdir_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = vdir_pkg::S_IDLE;
            end
         end
         vdir_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = vdir_pkg::S_WRITE;
            end
         end
         vdir_pkg::S_WRITE: begin
            cmd.write_head = 1'b1;
            state_in       = vdir_pkg::S_CLAMP;
         end
         vdir_pkg::S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = vdir_pkg::S_ADDR;
         end
         vdir_pkg::S_ADDR: begin
            cmd.addr = 1'b1;
            state_in = vdir_pkg::S_READ;
         end
         vdir_pkg::S_READ: begin
            cmd.read = 1'b1;
            state_in = vdir_pkg::S_BLEND;
         end
         vdir_pkg::S_BLEND: begin
            // hold until the output register can take the result
            if (!status.out_full) begin
               cmd.load_out = 1'b1;
               state_in     = vdir_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = vdir_pkg::S_CLEAR;
         end
      endcase
   end

   `ASSERT_NEXT(a_accept_to_write, clock, reset, req_valid && req_ready, state_ff == vdir_pkg::S_WRITE)
   `ASSERT_IMPLIES(a_load_needs_room, clock, reset, cmd.load_out, !status.out_full)
   `ASSERT_NEXT(a_blend_holds, clock, reset, (state_ff == vdir_pkg::S_BLEND) && status.out_full, state_ff == vdir_pkg::S_BLEND)
   `ASSERT_NEXT(a_clear_ends, clock, reset, (state_ff == vdir_pkg::S_CLEAR) && status.clear_done, state_ff == vdir_pkg::S_IDLE)

endmodule

@@ design/vdir_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdir_dpath
// Sample memory, head pointer, config registers, delay math and blend.
// ----------------------------------------------------------------------------
module vdir_dpath #(
   parameter int MAX_DEPTH = 65536,
   parameter int FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vdir_pkg::cmd_type                    cmd,
   output vdir_pkg::status_type                 status,
   input  logic signed [vdir_pkg::SAMPLE_W-1:0] write_sample,
   input  logic signed [vdir_pkg::DELAY_W-1:0]  delay_ms,
   input  logic                                 csr_write,
   input  logic [vdir_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vdir_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [vdir_pkg::SAMPLE_W-1:0] read_sample
);

   localparam int SW  = vdir_pkg::SAMPLE_W;
   localparam int PW  = vdir_pkg::PROD_W;
   localparam int AW  = $clog2(MAX_DEPTH);
   localparam int LW  = $clog2(MAX_DEPTH + 1);
   localparam int HW  = AW + 1;
   localparam int CW  = (LW > vdir_pkg::LEN_CFG_W) ? LW : vdir_pkg::LEN_CFG_W;
   localparam int TW  = LW + FRAC_BITS;
   localparam int SH  = 16 - FRAC_BITS;
   localparam int DQW = PW - 1 - SH;
   localparam int KW  = (DQW > TW) ? DQW : TW;
   localparam int BW  = SW + FRAC_BITS + 2;

   // configuration
   logic [vdir_pkg::RATE_W-1:0]    spm_ff;
   logic [vdir_pkg::LEN_CFG_W-1:0] blen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff  <= vdir_pkg::RATE_RESET;
         blen_ff <= vdir_pkg::LEN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            vdir_pkg::REG_SAMPLES_PER_MS: spm_ff  <= csr_data[vdir_pkg::RATE_W-1:0];
            vdir_pkg::REG_BUFFER_LENGTH:  blen_ff <= csr_data[vdir_pkg::LEN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] blen_x;
   logic [LW-1:0] len_c;

   assign blen_x = CW'(blen_ff);

   always_comb begin
      if (blen_x < CW'(2)) begin
         len_c = LW'(2);
      end else if (blen_x > CW'(MAX_DEPTH)) begin
         len_c = LW'(MAX_DEPTH);
      end else begin
         len_c = blen_x[LW-1:0];
      end
   end

   // clear sweep
   logic [AW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign status.clear_done = (clr_ff == AW'(MAX_DEPTH - 1));

   // head pointer
   logic [AW-1:0] head_ff;
   logic [AW-1:0] h_eff;
   logic [AW-1:0] h_next;
   logic [HW-1:0] hinc_x;

   assign h_eff  = (HW'(head_ff) >= HW'(len_c)) ? '0 : head_ff;
   assign hinc_x = HW'(h_eff) + HW'(1);
   assign h_next = (hinc_x >= HW'(len_c)) ? '0 : hinc_x[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else if (cmd.write_head) begin
         head_ff <= h_next;
      end
   end

   // input capture and rate product
   logic signed [SW-1:0]                  sample_ff;
   logic signed [vdir_pkg::DELAY_W-1:0]   delay_ff;
   logic signed [PW-1:0]                  prod_ff;
   logic [AW-1:0]                         hpos_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= write_sample;
         delay_ff  <= delay_ms;
      end
      if (cmd.write_head) begin
         prod_ff <= PW'(delay_ff) * PW'($signed({1'b0, spm_ff}));
         hpos_ff <= h_eff;
      end
   end

   // clamp
   logic [TW-1:0] limit_c;
   logic [KW-1:0] dq_raw;
   logic [TW-1:0] dq_ff;

   assign limit_c = {len_c, {FRAC_BITS{1'b0}}};
   assign dq_raw  = (prod_ff[PW-1] || (prod_ff == '0)) ? '0 : KW'(prod_ff[PW-2:SH]);

   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         dq_ff <= (dq_raw > KW'(limit_c)) ? limit_c : dq_raw[TW-1:0];
      end
   end

   // read address
   logic [TW-1:0]       base_c;
   logic [TW-1:0]       target_c;
   logic [LW-1:0]       x0_c;
   logic [LW-1:0]       x0_sel;
   logic [LW:0]         x1_x;
   logic [AW-1:0]       x1_sel;
   logic [AW-1:0]       x0_ff;
   logic [AW-1:0]       x1_ff;
   logic [FRAC_BITS-1:0] frac_ff;

   assign base_c   = TW'({hpos_ff, {FRAC_BITS{1'b0}}});
   assign target_c = (dq_ff > base_c) ? (base_c + limit_c - dq_ff) : (base_c - dq_ff);
   assign x0_c     = target_c[TW-1:FRAC_BITS];
   assign x0_sel   = (x0_c >= len_c) ? '0 : x0_c;
   assign x1_x     = (LW + 1)'(x0_sel) + (LW + 1)'(1);
   assign x1_sel   = (x1_x >= (LW + 1)'(len_c)) ? '0 : x1_x[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.addr) begin
         x0_ff   <= x0_sel[AW-1:0];
         x1_ff   <= x1_sel;
         frac_ff <= target_c[FRAC_BITS-1:0];
      end
   end

   // sample memory
   logic [SW-1:0] mem [MAX_DEPTH];
   logic [SW-1:0] rd0_ff;
   logic [SW-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_ff] <= '0;
      end else if (cmd.write_head) begin
         mem[h_eff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd0_ff <= mem[x0_ff];
         rd1_ff <= mem[x1_ff];
      end
   end

   // blend
   logic [SW:0]          diff_c;
   logic [BW-1:0]        y0_sh;
   logic signed [BW-1:0] blend_mul;
   logic [BW-1:0]        total_c;

   assign diff_c    = {rd1_ff[SW-1], rd1_ff} - {rd0_ff[SW-1], rd0_ff};
   assign y0_sh     = {{2{rd0_ff[SW-1]}}, rd0_ff, {FRAC_BITS{1'b0}}};
   assign blend_mul = BW'($signed(diff_c)) * BW'($signed({1'b0, frac_ff}));
   assign total_c   = y0_sh + blend_mul;

   // output register
   logic                 rsp_valid_ff;
   logic signed [SW-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= $signed(total_c[FRAC_BITS+SW-1:FRAC_BITS]);
      end
   end

   assign status.out_full = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign read_sample     = rsp_data_ff;

endmodule

@@ design/variable_delay_interp_read.sv @@
// Flow: after an input transfer the sequencer walks write, clamp, address,
// memory read and blend on a single sample memory; blend holds while the
// output holds a result not yet taken. No new input is taken until it is loaded.
// Reset: synchronous; afterwards the sample memory is cleared, one entry a
// cycle, with req ready low; configuration writes are taken.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_delay_interp_read
// Variable delay line with linear interpolation between neighboring samples.
// ----------------------------------------------------------------------------
module variable_delay_interp_read #(
   parameter int MAX_DEPTH = 65536,
   parameter int FRAC_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   vdir_req_if.sink   req_ch,
   vdir_rsp_if.source rsp_ch,
   vdir_csr_if.sink   csr_ch
);

   vdir_pkg::cmd_type    cmd;
   vdir_pkg::status_type status;
   logic                 ctrl_ready;

   assign req_ch.ready = ctrl_ready;
   assign csr_ch.ready = 1'b1;

   vdir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vdir_dpath #(
      .MAX_DEPTH (MAX_DEPTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .write_sample (req_ch.write_sample),
      .delay_ms     (req_ch.delay_ms),
      .csr_write    (csr_ch.valid),
      .csr_index    (csr_ch.index),
      .csr_data     (csr_ch.data),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .read_sample  (rsp_ch.read_sample)
   );

endmodule
